>>> rtl/core/lgs_pkg.sv
`default_nettype none

package lgs_pkg;

  // Grid dimensions
  localparam int unsigned MaxWidth  = 64;
  localparam int unsigned MaxHeight = 64;

  // Field widths
  localparam int unsigned RowW     = 64;
  localparam int unsigned RowIdxW  = 6;
  localparam int unsigned DimW     = 7;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 7;
  localparam int unsigned RowCntW  = $clog2(MaxHeight);
  localparam int unsigned CountW   = 4;

  // B3/S23 rule
  localparam logic [CountW-1:0] BirthCount = CountW'(3);
  localparam logic [CountW-1:0] SurviveLow = CountW'(2);

  // Register indexes
  localparam logic [CfgIdxW-1:0] CfgWidthIdx  = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgHeightIdx = 1'b1;

  // Operation codes
  localparam logic OpLoad = 1'b0;
  localparam logic OpStep = 1'b1;

  typedef logic [MaxWidth-1:0] row_t;

  typedef enum logic {
    LgsIdle,
    LgsStep
  } lgs_state_e;

  typedef struct packed {
    logic shift;
    logic load;
  } lgs_cell_ctrl_t;

  // Zero acts as one, anything above the maximum acts as the maximum.
  function automatic logic [DimW-1:0] clamp_dim(logic [DimW-1:0] v, int unsigned maxv);
    logic [DimW-1:0] res;
    res = v;
    if (v == '0) begin
      res = DimW'(1);
    end else if (32'(v) > maxv) begin
      res = DimW'(maxv);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/lgs_if.sv
`default_nettype none

interface lgs_in_if;
  logic                        valid;
  logic                        ready;
  logic                        op;
  logic [lgs_pkg::RowIdxW-1:0] row_index;
  logic [lgs_pkg::RowW-1:0]    row_cells;

  modport source (output valid, output op, output row_index, output row_cells, input ready);
  modport sink   (input valid, input op, input row_index, input row_cells, output ready);
endinterface

interface lgs_out_if;
  logic                        valid;
  logic                        ready;
  logic [lgs_pkg::RowIdxW-1:0] out_row;
  logic [lgs_pkg::RowW-1:0]    new_cells;
  logic [lgs_pkg::RowW-1:0]    changed_mask;
  logic                        last_row;

  modport source (output valid, output out_row, output new_cells, output changed_mask,
                  output last_row, input ready);
  modport sink   (input valid, input out_row, input new_cells, input changed_mask,
                  input last_row, output ready);
endinterface

`default_nettype wire

>>> rtl/core/lgs_row_cell.sv
`default_nettype none

module lgs_row_cell (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire lgs_pkg::lgs_cell_ctrl_t ctrl_i,
  input  wire lgs_pkg::row_t           shift_in_i,
  input  wire lgs_pkg::row_t           load_data_i,
  output      lgs_pkg::row_t           row_o
);

  lgs_pkg::row_t row_q;

  // Hold one grid row; take a loaded row or the neighbor's row on a shift.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
    end else if (ctrl_i.load) begin
      row_q <= load_data_i;
    end else if (ctrl_i.shift) begin
      row_q <= shift_in_i;
    end
  end

  assign row_o = row_q;

endmodule

`default_nettype wire

>>> rtl/core/lgs_next_row.sv
`default_nettype none

module lgs_next_row (
  input  wire lgs_pkg::row_t above_i,
  input  wire lgs_pkg::row_t here_i,
  input  wire lgs_pkg::row_t below_i,
  input  wire lgs_pkg::row_t wmask_i,
  output      lgs_pkg::row_t next_o
);

  // Pad with a dead column on each side: index c+1 is column c.
  logic [lgs_pkg::MaxWidth+1:0] above_p, here_p, below_p;

  assign above_p = {1'b0, above_i, 1'b0};
  assign here_p  = {1'b0, here_i,  1'b0};
  assign below_p = {1'b0, below_i, 1'b0};

  for (genvar c = 0; c < lgs_pkg::MaxWidth; c++) begin : g_col
    logic [lgs_pkg::CountW-1:0] count;
    logic                       alive;

    assign count = lgs_pkg::CountW'(above_p[c]) + lgs_pkg::CountW'(above_p[c+1])
                 + lgs_pkg::CountW'(above_p[c+2]) + lgs_pkg::CountW'(here_p[c])
                 + lgs_pkg::CountW'(here_p[c+2]) + lgs_pkg::CountW'(below_p[c])
                 + lgs_pkg::CountW'(below_p[c+1]) + lgs_pkg::CountW'(below_p[c+2]);
    assign alive = here_i[c];

    assign next_o[c] = wmask_i[c] & ((count == lgs_pkg::BirthCount) |
                                     (alive & (count == lgs_pkg::SurviveLow)));
  end

endmodule

`default_nettype wire

>>> rtl/core/life_generation_step_unit.sv
// Load: a transaction writes one grid row and gives no result.
// Step: the grid rotates once through the row chain, one row per cycle while the output
//   is not stalled; the result for each row in use is captured in the output register as
//   that row passes the chain head.
// A new transaction is taken only once the chain has made its full turn for the step before.
// Reset clears every grid row, sets width and height in use to 64, and empties the output.
`default_nettype none

module life_generation_step_unit (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  lgs_in_if.sink                              in_ch_i,
  lgs_out_if.source                           out_ch_o,
  input  wire logic                           cfg_we_i,
  input  wire logic [lgs_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  wire logic [lgs_pkg::CfgDataW-1:0]   cfg_data_i
);

  localparam logic [lgs_pkg::RowCntW-1:0] LastCnt = lgs_pkg::RowCntW'(lgs_pkg::MaxHeight - 1);

  lgs_pkg::lgs_state_e state_q, state_d;
  logic [lgs_pkg::RowCntW-1:0] row_q, row_d;
  lgs_pkg::row_t above_q, above_d;
  logic [lgs_pkg::DimW-1:0] width_q, height_q;
  logic [lgs_pkg::DimW-1:0] w_eff, h_eff;

  logic out_valid_q, out_valid_d;
  logic [lgs_pkg::RowIdxW-1:0] out_row_q;
  logic [lgs_pkg::RowW-1:0] new_cells_q, changed_q;
  logic last_row_q;

  lgs_pkg::row_t cell_row [lgs_pkg::MaxHeight];
  lgs_pkg::row_t wmask, here_m, below_m, next_row, wrap_row, load_data;
  logic in_fire, in_area, below_ok, advance;

  assign w_eff = lgs_pkg::clamp_dim(width_q, lgs_pkg::MaxWidth);
  assign h_eff = lgs_pkg::clamp_dim(height_q, lgs_pkg::MaxHeight);

  for (genvar c = 0; c < lgs_pkg::MaxWidth; c++) begin : g_wmask
    assign wmask[c] = (lgs_pkg::DimW'(c) < w_eff);
  end

  assign in_fire  = in_ch_i.valid & in_ch_i.ready;
  assign in_area  = (lgs_pkg::DimW'(row_q) < h_eff);
  assign below_ok = ((lgs_pkg::DimW'(row_q) + lgs_pkg::DimW'(1)) < h_eff);
  assign here_m   = cell_row[0] & wmask;
  assign below_m  = below_ok ? (cell_row[1] & wmask) : '0;
  assign advance  = (state_q == lgs_pkg::LgsStep) &
                    (~in_area | ~out_valid_q | out_ch_o.ready);
  assign load_data = in_ch_i.row_cells[lgs_pkg::MaxWidth-1:0];

  lgs_next_row u_next_row (
    .above_i (above_q),
    .here_i  (here_m),
    .below_i (below_m),
    .wmask_i (wmask),
    .next_o  (next_row)
  );

  // Rows outside the area in use pass through the rotation untouched.
  assign wrap_row = in_area ? ((cell_row[0] & ~wmask) | next_row) : cell_row[0];

  for (genvar i = 0; i < lgs_pkg::MaxHeight; i++) begin : g_cell
    lgs_pkg::lgs_cell_ctrl_t ctrl;
    lgs_pkg::row_t           shift_in;

    assign ctrl.shift = advance;
    assign ctrl.load  = in_fire & (in_ch_i.op == lgs_pkg::OpLoad) &
                        (in_ch_i.row_index == lgs_pkg::RowIdxW'(i));

    if (i == lgs_pkg::MaxHeight - 1) begin : g_tail
      assign shift_in = wrap_row;
    end else begin : g_body
      assign shift_in = cell_row[i+1];
    end

    lgs_row_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .shift_in_i  (shift_in),
      .load_data_i (load_data),
      .row_o       (cell_row[i])
    );
  end

  always_comb begin
    state_d = state_q;
    row_d   = row_q;
    above_d = above_q;
    unique case (state_q)
      lgs_pkg::LgsIdle: begin
        if (in_fire && in_ch_i.op == lgs_pkg::OpStep) begin
          state_d = lgs_pkg::LgsStep;
          row_d   = '0;
          above_d = '0;
        end
      end
      lgs_pkg::LgsStep: begin
        if (advance) begin
          above_d = here_m;
          row_d   = row_q + lgs_pkg::RowCntW'(1);
          if (row_q == LastCnt) begin
            state_d = lgs_pkg::LgsIdle;
          end
        end
      end
      default: state_d = lgs_pkg::LgsIdle;
    endcase
  end

  assign in_ch_i.ready = (state_q == lgs_pkg::LgsIdle);

  always_comb begin
    out_valid_d = out_valid_q;
    priority if (advance && in_area) begin
      out_valid_d = 1'b1;
    end else if (out_ch_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lgs_pkg::LgsIdle;
      row_q       <= '0;
      above_q     <= '0;
      out_valid_q <= 1'b0;
      width_q     <= lgs_pkg::DimW'(lgs_pkg::MaxWidth);
      height_q    <= lgs_pkg::DimW'(lgs_pkg::MaxHeight);
    end else begin
      state_q     <= state_d;
      row_q       <= row_d;
      above_q     <= above_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          lgs_pkg::CfgWidthIdx:  width_q  <= cfg_data_i[lgs_pkg::DimW-1:0];
          lgs_pkg::CfgHeightIdx: height_q <= cfg_data_i[lgs_pkg::DimW-1:0];
          default: ;
        endcase
      end
    end
  end

  // Capture the result of the row at the chain head.
  always_ff @(posedge clk_i) begin
    if (advance && in_area) begin
      out_row_q   <= lgs_pkg::RowIdxW'(row_q);
      new_cells_q <= lgs_pkg::RowW'(next_row);
      changed_q   <= lgs_pkg::RowW'((next_row ^ here_m) & wmask);
      last_row_q  <= ((lgs_pkg::DimW'(row_q) + lgs_pkg::DimW'(1)) == h_eff);
    end
  end

  assign out_ch_o.valid        = out_valid_q;
  assign out_ch_o.out_row      = out_row_q;
  assign out_ch_o.new_cells    = new_cells_q;
  assign out_ch_o.changed_mask = changed_q;
  assign out_ch_o.last_row     = last_row_q;

`ifndef NO_ASSERTIONS
  a_step_full_turn: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lgs_pkg::LgsIdle && $past(state_q) == lgs_pkg::LgsStep)
      |-> $past(row_q) == LastCnt)
    else $error("step ended before the grid made a full turn");

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lgs_pkg::LgsStep && in_area && out_valid_q && !out_ch_o.ready)
      |=> $stable(row_q) && $stable(cell_row[0]))
    else $error("chain advanced while the output was stalled");

  a_last_row_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && last_row_q)
      |-> lgs_pkg::DimW'(out_row_q) + lgs_pkg::DimW'(1) == h_eff)
    else $error("last row flag on a row other than the final row in use");
`endif

endmodule

`default_nettype wire

>>> sim/life_generation_step_unit_tb.sv
`timescale 1ns / 1ps

module life_generation_step_unit_tb;
  import lgs_pkg::*;

  localparam int unsigned RandomItems    = 480;
  localparam int unsigned SettleCycles   = MaxHeight + 16;
  localparam int unsigned LongHoldCycles = 300;
  localparam int unsigned MaxReports     = 40;
  localparam int unsigned NumDirected    = 28;

  typedef struct packed {
    logic [RowIdxW-1:0] row;
    row_t               cells;
    row_t               changed;
    logic               last;
  } gen_row_t;

  typedef enum logic {
    DirItem,
    DirDims
  } dir_kind_e;

  typedef struct packed {
    dir_kind_e           kind;
    logic [CfgDataW-1:0] dim_w;
    logic [CfgDataW-1:0] dim_h;
    logic                op;
    logic [RowIdxW-1:0]  row_index;
    row_t                row_cells;
    logic                typed;
    row_t                typed_cells;
    row_t                typed_changed;
  } dir_entry_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_data;

  lgs_in_if  in_ch ();
  lgs_out_if out_ch ();

  life_generation_step_unit i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_ch_i    (in_ch),
    .out_ch_o   (out_ch),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  // Shadow of the grid and of the registers.
  row_t                life_grid [MaxHeight];
  logic [DimW-1:0]     width_reg;
  logic [DimW-1:0]     height_reg;
  gen_row_t            gen_expect_q [$];
  dir_entry_t          dir_table [NumDirected];
  int unsigned         error_count;
  int unsigned         burst_left;
  logic                hold_req;
  logic                hold_done;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #20ms;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic int unsigned dim_in_use(logic [DimW-1:0] v, int unsigned maxv);
    if (v == '0) return 1;
    if (32'(v) > maxv) return maxv;
    return 32'(v);
  endfunction

  function automatic int unsigned live_at(row_t r, int col);
    if (col < 0 || col >= int'(MaxWidth)) return 0;
    return 32'(r[col]);
  endfunction

  task automatic predict_item(input logic op, input logic [RowIdxW-1:0] idx, input row_t cells,
                              output int unsigned n_rows);
    int unsigned w;
    int unsigned h;
    int unsigned cnt;
    row_t        wmask;
    row_t        above;
    row_t        here;
    row_t        below;
    row_t        next;
    gen_row_t    res;
    n_rows = 0;
    if (op == OpLoad) begin
      life_grid[idx] = cells;
    end else begin
      w     = dim_in_use(width_reg, MaxWidth);
      h     = dim_in_use(height_reg, MaxHeight);
      wmask = (w >= MaxWidth) ? '1 : ((row_t'(1) << w) - row_t'(1));
      above = '0;
      here  = life_grid[0] & wmask;
      for (int unsigned r = 0; r < h; r++) begin
        below = (r + 1 < h) ? (life_grid[r + 1] & wmask) : '0;
        next  = '0;
        for (int c = 0; c < int'(w); c++) begin
          cnt = 0;
          for (int d = -1; d <= 1; d++) begin
            cnt += live_at(above, c + d);
            cnt += live_at(below, c + d);
            if (d != 0) cnt += live_at(here, c + d);
          end
          if (here[c]) begin
            next[c] = (cnt >= SurviveLow) && (cnt <= BirthCount);
          end else begin
            next[c] = (cnt == BirthCount);
          end
        end
        // cells outside the width keep their stored bits
        life_grid[r] = (life_grid[r] & ~wmask) | next;
        res.row      = r[RowIdxW-1:0];
        res.cells    = next;
        res.changed  = (next ^ here) & wmask;
        res.last     = (r + 1 == h);
        gen_expect_q = {gen_expect_q, res};
        above = here;
        here  = below;
      end
      n_rows = h;
    end
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    error_count++;
    if (error_count <= MaxReports) begin
      $display("%0t: %s mismatch, got %h want %h", $time, what, got, want);
    end
  endtask

  function automatic row_t make_row();
    row_t a;
    row_t b;
    row_t c;
    a = {$urandom, $urandom};
    b = {$urandom, $urandom};
    c = {$urandom, $urandom};
    case ($urandom_range(5))
      0: return a & b & c;
      1: return a | b;
      2: return a;
      3: return ($urandom_range(1) == 0) ? '0 : '1;
      default: return row_t'(a[2:0] | 3'b010) << $urandom_range(61);
    endcase
  endfunction

  function automatic logic [CfgDataW-1:0] pick_dim();
    case ($urandom_range(9))
      0: return '0;
      1: return CfgDataW'(1);
      2: return CfgDataW'(64);
      3: return CfgDataW'($urandom_range(65, 127));
      default: return CfgDataW'($urandom_range(2, 64));
    endcase
  endfunction

  // Drive one transaction, with random gaps between bursts.
  task automatic send_item(input logic op, input logic [RowIdxW-1:0] idx, input row_t cells,
                           output int unsigned n_rows);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 10);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    in_ch.valid     <= 1'b1;
    in_ch.op        <= op;
    in_ch.row_index <= idx;
    in_ch.row_cells <= cells;
    do @(posedge clk_i); while (!in_ch.ready);
    predict_item(op, idx, cells, n_rows);
  endtask

  // Drain all results, then let the row chain finish its pass.
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (gen_expect_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_dims(input logic [CfgDataW-1:0] w, input logic [CfgDataW-1:0] h);
    cfg_we   <= 1'b1;
    cfg_idx  <= CfgWidthIdx;
    cfg_data <= w;
    @(posedge clk_i);
    width_reg = w;
    cfg_idx  <= CfgHeightIdx;
    cfg_data <= h;
    @(posedge clk_i);
    height_reg = h;
    cfg_we <= 1'b0;
  endtask

  initial begin
    int unsigned mode;
    int unsigned mode_left;
    int unsigned hold_cnt;
    mode      = 0;
    mode_left = 0;
    out_ch.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_done) begin
        out_ch.ready <= 1'b0;
        for (hold_cnt = 0; hold_cnt < LongHoldCycles; hold_cnt++) @(posedge clk_i);
        hold_done = 1'b1;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(3);
          mode_left = $urandom_range(16, 96);
        end
        mode_left--;
        case (mode)
          0: out_ch.ready <= 1'b1;
          1: out_ch.ready <= 1'($urandom_range(1));
          2: out_ch.ready <= ($urandom_range(3) == 0);
          default: out_ch.ready <= (mode_left % 3 != 0);
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    gen_row_t want;
    if (out_ch.valid && out_ch.ready) begin
      if (gen_expect_q.size() == 0) begin
        report_mismatch("unexpected result, out_row", 64'(out_ch.out_row), '0);
      end else begin
        want = gen_expect_q.pop_front();
        if (out_ch.out_row !== want.row) begin
          report_mismatch("out_row", 64'(out_ch.out_row), 64'(want.row));
        end
        if (out_ch.new_cells !== want.cells) begin
          report_mismatch("new_cells", out_ch.new_cells, want.cells);
        end
        if (out_ch.changed_mask !== want.changed) begin
          report_mismatch("changed_mask", out_ch.changed_mask, want.changed);
        end
        if (out_ch.last_row !== want.last) begin
          report_mismatch("last_row", 64'(out_ch.last_row), 64'(want.last));
        end
      end
    end
  end

  initial begin
    int unsigned         n_rows;
    int unsigned         random_sent;
    int unsigned         h_eff;
    int unsigned         fix_pos;
    logic [CfgDataW-1:0] w_cfg;
    logic [CfgDataW-1:0] h_cfg;
    logic [RowIdxW-1:0]  idx;
    gen_row_t            fix;

    rst_ni          <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.op        <= OpLoad;
    in_ch.row_index <= '0;
    in_ch.row_cells <= '0;
    cfg_we          <= 1'b0;
    cfg_idx         <= CfgWidthIdx;
    cfg_data        <= '0;
    width_reg   = DimW'(MaxWidth);
    height_reg  = DimW'(MaxHeight);
    error_count = 0;
    burst_left  = 0;
    random_sent = 0;
    hold_req    = 1'b0;
    hold_done   = 1'b0;
    for (int r = 0; r < MaxHeight; r++) life_grid[r] = '0;

    // kind, width, height, op, row, cells, typed, row 0 cells, row 0 changed
    dir_table = '{
      '{DirItem, 7'd0,   7'd0,   OpStep, 6'd0,  64'h0, 1'b1, 64'h0, 64'h0},
      '{DirItem, 7'd0,   7'd0,   OpLoad, 6'd0,  '1,    1'b0, 64'h0, 64'h0},
      '{DirItem, 7'd0,   7'd0,   OpLoad, 6'd63, '1,    1'b0, 64'h0, 64'h0},
      '{DirItem, 7'd0,   7'd0,   OpStep, 6'd0,  64'h0, 1'b1,
        64'h7FFF_FFFF_FFFF_FFFE, 64'h8000_0000_0000_0001},
      '{DirItem, 7'd0,   7'd0,   OpStep, 6'd63, '1,    1'b0, 64'h0, 64'h0},
      '{DirItem, 7'd0,   7'd0,   OpLoad, 6'd20, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 64'h0, 64'h0},
      '{DirItem, 7'd0,   7'd0,   OpLoad, 6'd21, 64'h5555_5555_5555_5555, 1'b0, 64'h0, 64'h0},
      '{DirItem, 7'd0,   7'd0,   OpLoad, 6'd22, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 64'h0, 64'h0},
      '{DirItem, 7'd0,   7'd0,   OpStep, 6'd21, 64'h0, 1'b0, 64'h0, 64'h0},
      '{DirDims, 7'd1,   7'd1,   OpLoad, 6'd0,  64'h0, 1'b0, 64'h0, 64'h0},
      '{DirItem, 7'd0,   7'd0,   OpLoad, 6'd0,  '1,    1'b0, 64'h0, 64'h0},
      '{DirItem, 7'd0,   7'd0,   OpStep, 6'd0,  64'h0, 1'b1, 64'h0, 64'h1},
      '{DirItem, 7'd0,   7'd0,   OpStep, 6'd0,  64'h0, 1'b1, 64'h0, 64'h0},
      '{DirDims, 7'd0,   7'd127, OpLoad, 6'd0,  64'h0, 1'b0, 64'h0, 64'h0},
      '{DirItem, 7'd0,   7'd0,   OpLoad, 6'd0,  64'h1, 1'b0, 64'h0, 64'h0},
      '{DirItem, 7'd0,   7'd0,   OpLoad, 6'd1,  64'h1, 1'b0, 64'h0, 64'h0},
      '{DirItem, 7'd0,   7'd0,   OpLoad, 6'd2,  64'h1, 1'b0, 64'h0, 64'h0},
      '{DirItem, 7'd0,   7'd0,   OpStep, 6'd0,  64'h0, 1'b0, 64'h0, 64'h0},
      '{DirDims, 7'd127, 7'd0,   OpLoad, 6'd0,  64'h0, 1'b0, 64'h0, 64'h0},
      '{DirItem, 7'd0,   7'd0,   OpLoad, 6'd0,  64'h8000_0000_0000_0007, 1'b0, 64'h0, 64'h0},
      '{DirItem, 7'd0,   7'd0,   OpStep, 6'd0,  64'h0, 1'b0, 64'h0, 64'h0},
      '{DirDims, 7'd65,  7'd65,  OpLoad, 6'd0,  64'h0, 1'b0, 64'h0, 64'h0},
      '{DirItem, 7'd0,   7'd0,   OpLoad, 6'd62, 64'h8000_0000_0000_0001, 1'b0, 64'h0, 64'h0},
      '{DirItem, 7'd0,   7'd0,   OpLoad, 6'd63, 64'hC000_0000_0000_0003, 1'b0, 64'h0, 64'h0},
      '{DirItem, 7'd0,   7'd0,   OpStep, 6'd0,  64'h0, 1'b0, 64'h0, 64'h0},
      '{DirDims, 7'd3,   7'd3,   OpLoad, 6'd0,  64'h0, 1'b0, 64'h0, 64'h0},
      '{DirItem, 7'd0,   7'd0,   OpLoad, 6'd1,  64'h7, 1'b0, 64'h0, 64'h0},
      '{DirItem, 7'd0,   7'd0,   OpStep, 6'd0,  64'h0, 1'b0, 64'h0, 64'h0}
    };

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_table[i]) begin
      if (dir_table[i].kind == DirDims) begin
        wait_idle();
        write_dims(dir_table[i].dim_w, dir_table[i].dim_h);
      end else begin
        send_item(dir_table[i].op, dir_table[i].row_index, dir_table[i].row_cells, n_rows);
        // replace row 0 of this step with the value typed in the table
        if (dir_table[i].typed) begin
          fix_pos     = gen_expect_q.size() - n_rows;
          fix         = gen_expect_q[fix_pos];
          fix.cells   = dir_table[i].typed_cells;
          fix.changed = dir_table[i].typed_changed;
          gen_expect_q[fix_pos] = fix;
        end
      end
    end

    // Each phase: new dimensions, then generations of loads followed by steps.
    while (random_sent < RandomItems) begin
      w_cfg = pick_dim();
      h_cfg = pick_dim();
      wait_idle();
      write_dims(w_cfg, h_cfg);
      h_eff = dim_in_use(h_cfg, MaxHeight);
      repeat ($urandom_range(1, 5)) begin
        repeat ($urandom_range(0, 6)) begin
          if ($urandom_range(7) == 0) begin
            idx = RowIdxW'($urandom_range(MaxHeight - 1));
          end else begin
            idx = RowIdxW'($urandom_range(h_eff - 1));
          end
          send_item(OpLoad, idx, make_row(), n_rows);
          random_sent++;
        end
        // stall the output for a long stretch while steps keep coming
        if (!hold_req && random_sent >= RandomItems / 3) hold_req = 1'b1;
        repeat ($urandom_range(1, 3)) begin
          send_item(OpStep, RowIdxW'($urandom), make_row(), n_rows);
          random_sent++;
        end
      end
    end

    wait_idle();
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/lgs_pkg.sv
rtl/core/lgs_if.sv
rtl/core/lgs_row_cell.sv
rtl/core/lgs_next_row.sv
rtl/core/life_generation_step_unit.sv
sim/life_generation_step_unit_tb.sv
